// File: src/lsmpq_pkg.sv
// Shared types and constants for the linear-scan min priority queue.
package lsmpq_pkg;

	localparam int NODE_W    = 16;
	localparam int PRIO_W    = 16;
	localparam int POS_W     = 4;
	localparam int CMD_W     = 2;
	localparam int CNT_OUT_W = 5;
	localparam int ENTRY_W   = NODE_W + PRIO_W;

	// command codes on the cmd port
	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET     = 2'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd3;

	// priority value that stands for infinite
	localparam logic signed [PRIO_W-1:0] PRIO_INF = -16'sd1;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_EXTRACT,
		OP_SET,
		OP_REMOVE
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_GRAB,
		S_SHIFT
	} state_t;

	// classified request handed from the front queue to the executor
	typedef struct packed {
		op_t                      op;
		logic [NODE_W-1:0]        node;
		logic signed [PRIO_W-1:0] prio;
		logic [POS_W-1:0]         pos;
	} req_t;

	// result payload from the executor
	typedef struct packed {
		status_t                  status;
		logic [NODE_W-1:0]        node;
		logic signed [PRIO_W-1:0] prio;
	} res_t;

endpackage

// File: src/lsmpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsmpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/lsmpq_front.sv
// Front end: decodes incoming requests and holds them in a two-entry queue.
module lsmpq_front import lsmpq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [NODE_W-1:0]        node_id,
	input  logic signed [PRIO_W-1:0] priority_req,
	input  logic [POS_W-1:0]         position,
	output logic                     cq_valid,
	output req_t                     cq_req,
	input  logic                     cq_pop
);

	req_t       ent_q [2];
	req_t       new_req;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push_ok;

	// classify the command
	always_comb begin
		new_req.node = node_id;
		new_req.prio = priority_req;
		new_req.pos  = position;
		unique case (cmd)
			CMD_INSERT:  new_req.op = OP_INSERT;
			CMD_EXTRACT: new_req.op = OP_EXTRACT;
			CMD_SET:     new_req.op = OP_SET;
			CMD_REMOVE:  new_req.op = OP_REMOVE;
		endcase
	end

	assign full     = (fill_q == 2'd2);
	assign push_ok  = push & ~full;
	assign cq_valid = (fill_q != 2'd0);
	assign cq_req   = ent_q[rd_ptr_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cq_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push_ok) - 2'(cq_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			ent_q[wr_ptr_q] <= new_req;
		end
	end

endmodule

// File: src/lsmpq_back.sv
// Back end: executes requests against the entry table, at most one table read per cycle.
module lsmpq_back import lsmpq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cq_valid,
	input  req_t                             cq_req,
	output logic                             cq_pop,
	output logic                             res_valid,
	output res_t                             res,
	output logic [$clog2(CAPACITY+1)-1:0]    res_cnt,
	input  logic                             res_pop
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	state_t state_q, state_d;

	// control
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic          found_q;
	logic          res_valid_q;

	// payload
	req_t                     req_q;
	logic [AW-1:0]            rd_idx_s1;
	logic [AW-1:0]            best_idx_q;
	logic [NODE_W-1:0]        best_node_q;
	logic signed [PRIO_W-1:0] best_prio_q;
	res_t                     res_q;
	logic [CW-1:0]            res_cnt_q;

	// table port
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	// decode helpers
	logic                     start;
	logic                     scan_more;
	logic                     tbl_full;
	logic                     tbl_empty;
	logic [PW-1:0]            pos_x;
	logic                     pos_ok;
	logic [NODE_W-1:0]        rd_node;
	logic signed [PRIO_W-1:0] rd_prio;
	logic                     match;
	logic                     better;
	logic                     scan_fin;
	logic                     shift_fin;

	lsmpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_tbl (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign start     = (state_q == S_IDLE) && cq_valid && !res_valid_q;
	assign scan_more = (idx_q < cnt_q);
	assign tbl_full  = (cnt_q >= CAP_C);
	assign tbl_empty = (cnt_q == '0);
	assign pos_x     = PW'(cq_req.pos);
	assign pos_ok    = (pos_x < PW'(cnt_q));
	assign rd_node   = rd_data[ENTRY_W-1:PRIO_W];
	assign rd_prio   = rd_data[PRIO_W-1:0];

	// first matching node stops the set-priority scan
	assign match  = (state_q == S_SCAN) && (req_q.op == OP_SET) && rd_vld_s1
		&& !found_q && (rd_node == req_q.node);
	// strictly smaller, non-infinite priority wins; entry 0 seeds the search
	assign better = (state_q == S_SCAN) && (req_q.op == OP_EXTRACT) && rd_vld_s1
		&& ((rd_idx_s1 == '0) || ((rd_prio < best_prio_q) && (rd_prio != PRIO_INF)));
	assign scan_fin  = !rd_vld_s1 && (!scan_more || found_q);
	assign shift_fin = !rd_vld_s1 && !scan_more;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cq_req.op)
						OP_INSERT:  state_d = S_IDLE;
						OP_EXTRACT: state_d = tbl_empty ? S_IDLE : S_SCAN;
						OP_SET:     state_d = S_SCAN;
						OP_REMOVE:  state_d = (!tbl_empty && pos_ok) ? S_GRAB : S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_fin) begin
					state_d = (req_q.op == OP_EXTRACT) ? S_SHIFT : S_IDLE;
				end
			end
			S_GRAB: begin
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (shift_fin) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// table access and queue pop
	always_comb begin
		cq_pop  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cq_pop = 1'b1;
					if (cq_req.op == OP_INSERT && !tbl_full) begin
						wr_en   = 1'b1;
						wr_addr = cnt_q[AW-1:0];
						wr_data = {cq_req.node, cq_req.prio};
					end
					if (cq_req.op == OP_REMOVE && !tbl_empty && pos_ok) begin
						rd_en   = 1'b1;
						rd_addr = pos_x[AW-1:0];
					end
				end
			end
			S_SCAN: begin
				rd_en = scan_more && !found_q && !match;
				if (match) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1;
					wr_data = {rd_node, req_q.prio};
				end
			end
			S_GRAB: begin
				rd_en = 1'b0;
			end
			S_SHIFT: begin
				// read entry i+1, write it to i on the next cycle
				rd_en = scan_more;
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1 - AW'(1);
					wr_data = rd_data;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (res_pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						// removal shifts from the entry after the victim, scans start at 0
						idx_q   <= (cq_req.op == OP_REMOVE) ? CW'(pos_x) + CW'(1) : '0;
						found_q <= 1'b0;
						unique case (cq_req.op)
							OP_INSERT: begin
								res_valid_q <= 1'b1;
								if (!tbl_full) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							OP_EXTRACT: begin
								if (tbl_empty) begin
									res_valid_q <= 1'b1;
								end
							end
							OP_SET: begin
							end
							OP_REMOVE: begin
								if (tbl_empty || !pos_ok) begin
									res_valid_q <= 1'b1;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (match) begin
						found_q <= 1'b1;
					end
					if (scan_fin) begin
						if (req_q.op == OP_EXTRACT) begin
							idx_q <= CW'(best_idx_q) + CW'(1);
						end else begin
							res_valid_q <= 1'b1;
						end
					end
				end
				S_GRAB: begin
					found_q <= 1'b0;
				end
				S_SHIFT: begin
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (shift_fin) begin
						cnt_q       <= cnt_q - CW'(1);
						res_valid_q <= 1'b1;
					end
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (start) begin
			req_q      <= cq_req;
			res_q.node <= '0;
			res_q.prio <= '0;
			unique case (cq_req.op)
				OP_INSERT: begin
					res_q.status <= tbl_full ? ST_FULL : ST_OK;
					res_cnt_q    <= tbl_full ? cnt_q : cnt_q + CW'(1);
				end
				OP_EXTRACT: begin
					res_q.status <= tbl_empty ? ST_EMPTY : ST_OK;
					res_cnt_q    <= cnt_q;
				end
				OP_SET: begin
					res_q.status <= ST_OK;
					res_cnt_q    <= cnt_q;
				end
				OP_REMOVE: begin
					res_q.status <= tbl_empty ? ST_EMPTY : (pos_ok ? ST_OK : ST_RANGE);
					res_cnt_q    <= cnt_q;
				end
			endcase
		end
		if (better) begin
			best_idx_q  <= rd_idx_s1;
			best_node_q <= rd_node;
			best_prio_q <= rd_prio;
		end
		if (state_q == S_GRAB) begin
			best_node_q <= rd_node;
			best_prio_q <= rd_prio;
		end
		// set-priority outcome
		if (state_q == S_SCAN && scan_fin && req_q.op == OP_SET) begin
			res_q.status <= found_q ? ST_OK : ST_NOT_FOUND;
			res_cnt_q    <= cnt_q;
		end
		// removal outcome
		if (state_q == S_SHIFT && shift_fin) begin
			res_q.status <= ST_OK;
			res_q.node   <= best_node_q;
			res_q.prio   <= best_prio_q;
			res_cnt_q    <= cnt_q - CW'(1);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign res_cnt   = res_cnt_q;

endmodule

// File: src/linear_scan_min_priority_queue.sv
// Top level of the linear-scan min priority queue: front queue, executor, result ports.
//
//  channel   handshake              payload
//  request   push / full            cmd, node_id, priority_req, position
//  result    empty / pop            status, out_node, out_priority, count, is_empty
//
// Insert and the empty, full and range refusals finish in the cycle that takes the request.
// Extract, set priority and remove-at step through the entry table, read one entry per
// cycle, so their duration grows with the number of entries scanned or shifted. The next
// request starts the cycle after the result is popped. Reset clears the queue fill levels,
// the entry count and the state; table contents need no clearing. Up to two requests
// wait in the front queue while the executor works or while a result waits to be popped.
module linear_scan_min_priority_queue import lsmpq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [CMD_W-1:0]         cmd,
	input  logic [NODE_W-1:0]        node_id,
	input  logic signed [PRIO_W-1:0] priority_req,
	input  logic [POS_W-1:0]         position,
	output logic                     empty,
	input  logic                     pop,
	output logic [2:0]               status,
	output logic [NODE_W-1:0]        out_node,
	output logic signed [PRIO_W-1:0] out_priority,
	output logic [CNT_OUT_W-1:0]     count,
	output logic                     is_empty
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                  cq_valid;
	req_t                  cq_req;
	logic                  cq_pop;
	logic                  res_valid;
	res_t                  res;
	logic [CW-1:0]         res_cnt;
	logic                  res_pop;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	lsmpq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.node_id     (node_id),
		.priority_req(priority_req),
		.position    (position),
		.cq_valid    (cq_valid),
		.cq_req      (cq_req),
		.cq_pop      (cq_pop)
	);

	lsmpq_back #(
		.CAPACITY(CAPACITY)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_valid (cq_valid),
		.cq_req   (cq_req),
		.cq_pop   (cq_pop),
		.res_valid(res_valid),
		.res      (res),
		.res_cnt  (res_cnt),
		.res_pop  (res_pop)
	);

	// result ports; count is reported modulo 32
	assign empty        = ~res_valid;
	assign res_pop      = pop & res_valid;
	assign status       = res.status;
	assign out_node     = res.node;
	assign out_priority = res.prio;
	assign cnt_ext      = {{CNT_OUT_W{1'b0}}, res_cnt};
	assign count        = cnt_ext[CNT_OUT_W-1:0];
	assign is_empty     = (res_cnt == '0);

	// a full front queue always offers a request to the executor
	a_full_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cq_valid)
		else $error("front queue full but no request visible");

	// status codes stay in the defined range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= ST_RANGE))
		else $error("undefined status code");

	// an empty-table refusal leaves the table empty
	a_empty_stat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_EMPTY) |-> is_empty)
		else $error("empty status with entries left");

	// a full refusal never reports an empty table
	a_full_stat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_FULL) |-> !is_empty)
		else $error("full status with empty table");

	// no request is taken from the front queue while a result is still waiting
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> empty)
		else $error("request started while result pending");

endmodule

// File: bench/tb_linear_scan_min_priority_queue.sv
// Testbench for linear_scan_min_priority_queue: queued driver, result monitor, table predictor.
`timescale 1ns / 1ps

module tb_linear_scan_min_priority_queue;
	import lsmpq_pkg::*;

	localparam int QUEUE_DEPTH   = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 60;
	localparam int RANDOM_COUNT  = 925;
	localparam int PRESSURE_AT   = 300;
	localparam int PRESSURE_HOLD = 250;
	localparam int MAX_REPORTS   = 10;

	// table copies: one follows generation, one follows accepted requests
	localparam int SHADOW_GEN = 0;
	localparam int SHADOW_CHK = 1;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [NODE_W-1:0]        node;
		logic signed [PRIO_W-1:0] prio;
		logic [POS_W-1:0]         pos;
	} pq_request_t;

	typedef struct packed {
		status_t                  status;
		logic [NODE_W-1:0]        node;
		logic signed [PRIO_W-1:0] prio;
		logic [CNT_OUT_W-1:0]     fill;
		logic                     drained;
	} pq_outcome_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic [CMD_W-1:0]         cmd = '0;
	logic [NODE_W-1:0]        node_id = '0;
	logic signed [PRIO_W-1:0] priority_req = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic [2:0]               status;
	logic [NODE_W-1:0]        out_node;
	logic signed [PRIO_W-1:0] out_priority;
	logic [CNT_OUT_W-1:0]     count;
	logic                     is_empty;

	logic [NODE_W-1:0]        tbl_node [2][QUEUE_DEPTH];
	logic signed [PRIO_W-1:0] tbl_prio [2][QUEUE_DEPTH];
	int                       tbl_cnt [2];

	pq_request_t request_q [$];
	pq_outcome_t outcome_q [$];
	pq_request_t next_req;
	pq_outcome_t want;

	bit          req_taken = 1'b0;
	bit          res_taken = 1'b0;
	int          req_total = 0;
	int          fault_count = 0;
	int          idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned send_burst = 0;
	int unsigned recv_gap = 0;
	int unsigned recv_burst = 0;
	int          pressure_done = 0;

	linear_scan_min_priority_queue #(
		.CAPACITY(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.node_id(node_id),
		.priority_req(priority_req),
		.position(position),
		.empty(empty),
		.pop(pop),
		.status(status),
		.out_node(out_node),
		.out_priority(out_priority),
		.count(count),
		.is_empty(is_empty)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run one command against table copy w and return its result
	function automatic pq_outcome_t pq_execute(input int w, input pq_request_t rq);
		pq_outcome_t res;
		int          victim;
		int          idx;
		res.status = ST_OK;
		res.node = '0;
		res.prio = '0;
		victim = -1;
		case (rq.cmd)
			CMD_INSERT: begin
				if (tbl_cnt[w] >= QUEUE_DEPTH)
					res.status = ST_FULL;
				else begin
					tbl_node[w][tbl_cnt[w]] = rq.node;
					tbl_prio[w][tbl_cnt[w]] = rq.prio;
					tbl_cnt[w]++;
				end
			end
			CMD_EXTRACT: begin
				if (tbl_cnt[w] == 0)
					res.status = ST_EMPTY;
				else begin
					// entry 0 is the seed even at infinity; later ones must beat it strictly
					victim = 0;
					for (idx = 1; idx < tbl_cnt[w]; idx++)
						if (tbl_prio[w][idx] < tbl_prio[w][victim] &&
							tbl_prio[w][idx] != PRIO_INF)
							victim = idx;
				end
			end
			CMD_SET: begin
				res.status = ST_NOT_FOUND;
				for (idx = 0; idx < tbl_cnt[w]; idx++)
					if (res.status == ST_NOT_FOUND && tbl_node[w][idx] == rq.node) begin
						tbl_prio[w][idx] = rq.prio;
						res.status = ST_OK;
					end
			end
			default: begin
				if (tbl_cnt[w] == 0)
					res.status = ST_EMPTY;
				else if (int'(rq.pos) >= tbl_cnt[w])
					res.status = ST_RANGE;
				else
					victim = int'(rq.pos);
			end
		endcase
		// take out the chosen entry, later ones slide down
		if (victim >= 0) begin
			res.node = tbl_node[w][victim];
			res.prio = tbl_prio[w][victim];
			for (idx = victim; idx + 1 < tbl_cnt[w]; idx++) begin
				tbl_node[w][idx] = tbl_node[w][idx + 1];
				tbl_prio[w][idx] = tbl_prio[w][idx + 1];
			end
			tbl_cnt[w]--;
		end
		res.fill = tbl_cnt[w][CNT_OUT_W-1:0];
		res.drained = (tbl_cnt[w] == 0);
		return res;
	endfunction

	// Idle length: mostly short, a few long, with bursts of back-to-back traffic
	function automatic int unsigned draw_gap(inout int unsigned burst);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (burst != 0) begin
			burst--;
			return 0;
		end
		if (roll < 2)
			burst = $urandom_range(20, 80);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Node ids drawn from a small pool so duplicates show up
	function automatic logic [NODE_W-1:0] pick_node();
		if ($urandom_range(0, 99) < 70)
			return NODE_W'($urandom_range(0, 15));
		return NODE_W'($urandom_range(0, 65535));
	endfunction

	// Priorities weighted toward infinity, the top value, zero and ties
	function automatic logic signed [PRIO_W-1:0] pick_prio();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return PRIO_INF;
		if (roll < 25)
			return 16'sd32767;
		if (roll < 35)
			return '0;
		if (roll < 75)
			return PRIO_W'($urandom_range(0, 20));
		return PRIO_W'($urandom_range(0, 32767));
	endfunction

	task automatic queue_request(input logic [CMD_W-1:0] op, input logic [NODE_W-1:0] nd,
		input logic signed [PRIO_W-1:0] pr, input logic [POS_W-1:0] ps);
		pq_request_t rq;
		rq.cmd = op;
		rq.node = nd;
		rq.prio = pr;
		rq.pos = ps;
		void'(pq_execute(SHADOW_GEN, rq));
		request_q.push_back(rq);
	endtask

	task automatic note_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	// Stimulus, reset and end of run
	initial begin
		int          n;
		int unsigned roll;
		int unsigned ins_weight;
		int          fill_goal;
		logic [NODE_W-1:0] nd;
		tbl_cnt[SHADOW_GEN] = 0;
		tbl_cnt[SHADOW_CHK] = 0;
		fill_goal = QUEUE_DEPTH;

		// empty-table cases
		queue_request(CMD_EXTRACT, 16'h0000, 16'sd0, 4'd0);
		queue_request(CMD_REMOVE, 16'h0000, 16'sd0, 4'd0);
		queue_request(CMD_SET, 16'h0001, 16'sd3, 4'd0);
		// fill up, infinite entry at the head, field extremes, ties
		queue_request(CMD_INSERT, 16'h0000, PRIO_INF, 4'd0);
		queue_request(CMD_INSERT, 16'hFFFF, 16'sd32767, 4'd15);
		queue_request(CMD_INSERT, 16'h0001, 16'sd0, 4'd0);
		queue_request(CMD_INSERT, 16'h8000, PRIO_INF, 4'd0);
		for (n = 4; n < QUEUE_DEPTH; n++)
			queue_request(CMD_INSERT, NODE_W'(16'h0100 + n), PRIO_W'((n * 3) % 5), 4'd0);
		queue_request(CMD_INSERT, 16'h7777, 16'sd5, 4'd0);
		queue_request(CMD_EXTRACT, 16'h0000, 16'sd0, 4'd0);
		queue_request(CMD_SET, 16'h0001, 16'sd2, 4'd0);
		queue_request(CMD_SET, 16'h4242, 16'sd2, 4'd0);
		queue_request(CMD_REMOVE, 16'h0000, 16'sd0, 4'd15);
		queue_request(CMD_REMOVE, 16'h0000, 16'sd0, 4'd14);

		// random traffic steered by a wandering fill target
		for (n = 0; n < RANDOM_COUNT; n++) begin
			if (n % 40 == 0)
				fill_goal = ($urandom_range(0, 3) == 0) ? QUEUE_DEPTH :
					$urandom_range(0, QUEUE_DEPTH);
			ins_weight = (tbl_cnt[SHADOW_GEN] < fill_goal) ? 65 : 20;
			roll = $urandom_range(0, 99);
			if (roll < ins_weight)
				queue_request(CMD_INSERT, pick_node(), pick_prio(), POS_W'($urandom()));
			else if (roll < ins_weight + (100 - ins_weight) / 2)
				queue_request(CMD_EXTRACT, NODE_W'($urandom()), PRIO_W'($urandom()),
					POS_W'($urandom()));
			else if (roll < ins_weight + 3 * (100 - ins_weight) / 4) begin
				nd = pick_node();
				if (tbl_cnt[SHADOW_GEN] != 0 && $urandom_range(0, 99) < 80)
					nd = tbl_node[SHADOW_GEN][$urandom_range(0, tbl_cnt[SHADOW_GEN] - 1)];
				queue_request(CMD_SET, nd, pick_prio(), POS_W'($urandom()));
			end else if (tbl_cnt[SHADOW_GEN] != 0 && $urandom_range(0, 99) < 80)
				queue_request(CMD_REMOVE, NODE_W'($urandom()), PRIO_W'($urandom()),
					POS_W'($urandom_range(0, tbl_cnt[SHADOW_GEN] - 1)));
			else
				queue_request(CMD_REMOVE, NODE_W'($urandom()), PRIO_W'($urandom()),
					POS_W'($urandom_range(0, 15)));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || push)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && outcome_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Request driver: holds a request until taken, then idles or offers the next
	always @(negedge clk) begin
		if (arst_n) begin
			if (push && !req_taken) begin
				// request still waiting for acceptance
			end else if (send_gap != 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (request_q.size() != 0) begin
				next_req = request_q.pop_front();
				push <= 1'b1;
				cmd <= next_req.cmd;
				node_id <= next_req.node;
				priority_req <= next_req.prio;
				position <= next_req.pos;
				send_gap = draw_gap(send_burst);
			end else
				push <= 1'b0;
		end
	end

	// Result consumer: random stalls, plus long hold-offs to back up the input
	always @(negedge clk) begin
		if (arst_n) begin
			if (pressure_done < 2 && req_total >= PRESSURE_AT * (pressure_done + 1)) begin
				pressure_done++;
				recv_gap = PRESSURE_HOLD;
			end
			if (res_taken && recv_gap == 0)
				recv_gap = draw_gap(recv_burst);
			if (recv_gap != 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else
				pop <= 1'b1;
		end
	end

	// Monitor: check results against the oldest prediction, then predict new requests
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = push && !full;
			res_taken = pop && !empty;
			if (res_taken) begin
				if (outcome_q.size() == 0)
					note_fault($sformatf("unexpected result status=%0d node=%h prio=%0d",
						status, out_node, out_priority));
				else begin
					want = outcome_q.pop_front();
					if (status !== want.status || out_node !== want.node ||
						out_priority !== want.prio || count !== want.fill ||
						is_empty !== want.drained)
						note_fault($sformatf({"mismatch exp status=%0d node=%h prio=%0d ",
							"count=%0d is_empty=%0b, got status=%0d node=%h prio=%0d ",
							"count=%0d is_empty=%0b"}, want.status, want.node, want.prio,
							want.fill, want.drained, status, out_node, out_priority,
							count, is_empty));
				end
			end
			if (req_taken) begin
				next_req.cmd = cmd;
				next_req.node = node_id;
				next_req.prio = priority_req;
				next_req.pos = position;
				outcome_q.push_back(pq_execute(SHADOW_CHK, next_req));
				req_total++;
			end
		end
	end

	// Watchdog on cycles with no request and no result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule
